// ===== rtl/core/rrm_pkg.sv =====
// Shared types, constants and codes for the RAID request mapper.
package rrm_pkg;
	localparam int MaxDisks = 8;
	localparam int BlockIndexBits = 24;
	localparam int DiskIdxW = $clog2(MaxDisks);
	localparam int LbW = 27;
	localparam int BpdW = 25;

	localparam logic [1:0] ACT_READ = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_FAIL = 2'd2;
	localparam logic [1:0] ACT_REPAIR = 2'd3;

	localparam logic [1:0] OP_READ = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_NONE = 2'd2;

	localparam logic [1:0] ROLE_DATA = 2'd0;
	localparam logic [1:0] ROLE_PARITY = 2'd1;
	localparam logic [1:0] ROLE_MIRROR = 2'd2;
	localparam logic [1:0] ROLE_RECON = 2'd3;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_DISABLED = 3'd1;
	localparam logic [2:0] ST_RANGE = 3'd2;
	localparam logic [2:0] ST_NO_COPY = 3'd3;
	localparam logic [2:0] ST_NO_REBUILD = 3'd4;

	localparam logic [2:0] LVL_RAID0 = 3'd0;
	localparam logic [2:0] LVL_RAID1 = 3'd1;
	localparam logic [2:0] LVL_RAID10 = 3'd2;
	localparam logic [2:0] LVL_RAID4 = 3'd3;
	localparam logic [2:0] LVL_RAID5 = 3'd4;

	localparam logic [1:0] CFG_LEVEL = 2'd0;
	localparam logic [1:0] CFG_COUNT = 2'd1;
	localparam logic [1:0] CFG_BPD = 2'd2;
	localparam logic [1:0] CFG_ENABLE = 2'd3;

	typedef struct packed {
		logic [1:0] action;
		logic [LbW-1:0] logical_block;
		logic [3:0] disk_number;
	} req_t;

	typedef struct packed {
		logic [1:0] disk_op;
		logic [3:0] target_disk;
		logic [BlockIndexBits-1:0] physical_block;
		logic [1:0] role;
		logic [2:0] status;
		logic last;
	} cmd_t;

	// Classified job handed from the front part to the back part.
	typedef struct packed {
		logic [2:0] level;
		logic wr;
		logic [2:0] err;
		logic [LbW-1:0] lb;
		logic [3:0] n;
		logic [MaxDisks-1:0] health;
	} job_t;

	typedef enum logic [2:0] {
		BK_IDLE, BK_DIV1, BK_DIV2, BK_CHECK, BK_EMIT
	} bk_state_t;
endpackage

// ===== rtl/core/rrm_divider.sv =====
// Restoring divider, one quotient bit per cycle.
module rrm_divider import rrm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [LbW-1:0] dividend,
	input logic [3:0] divisor,
	output logic done,
	output logic [LbW-1:0] quotient,
	output logic [3:0] remainder
);
	logic [LbW-1:0] quo_q;
	logic [4:0] rem_q;
	logic [3:0] dv_q;
	logic [4:0] cnt_q;
	logic busy_q;
	logic [4:0] trial;
	logic [4:0] diff;

	assign trial = {rem_q[3:0], quo_q[LbW-1]};
	assign diff = trial - {1'b0, dv_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'(LbW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	// The divisor is held for the whole division.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dv_q <= divisor;
		end else if (busy_q) begin
			if (!diff[4]) begin
				rem_q <= diff;
				quo_q <= {quo_q[LbW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[LbW-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
	assign remainder = rem_q[3:0];
endmodule

// ===== rtl/core/rrm_front.sv =====
// Front part: accepts requests, keeps disk health and classifies errors.
module rrm_front import rrm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input req_t req,
	input logic [2:0] raid_level,
	input logic [3:0] disk_count,
	input logic array_enabled,
	output logic job_valid,
	input logic job_take,
	output job_t job
);
	localparam int Depth = 2;
	job_t fifo_q [Depth];
	logic [0:0] wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic [MaxDisks-1:0] health_q;
	logic acc, enq;
	logic [3:0] n_clamp;
	job_t nj;

	assign full = (cnt_q == 2'(Depth));
	assign acc = push && !full;
	assign enq = acc && (req.action == ACT_READ || req.action == ACT_WRITE);
	assign job_valid = (cnt_q != 2'd0);
	assign job = fifo_q[rd_ptr_q];

	always_comb begin
		if (disk_count < 4'd2) n_clamp = 4'd2;
		else if (disk_count > 4'(MaxDisks)) n_clamp = 4'(MaxDisks);
		else n_clamp = disk_count;
		nj.level = raid_level;
		nj.wr = (req.action == ACT_WRITE);
		nj.lb = req.logical_block;
		nj.n = n_clamp;
		nj.health = health_q;
		if (!array_enabled || raid_level > LVL_RAID5) nj.err = ST_DISABLED;
		else nj.err = ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			health_q <= '1;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (acc && !enq && req.disk_number >= 4'd1 &&
					req.disk_number <= 4'(MaxDisks))
				health_q[DiskIdxW'(req.disk_number - 4'd1)] <=
					(req.action == ACT_REPAIR);
			if (enq) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (job_take && job_valid) rd_ptr_q <= rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + 2'(enq) - 2'(job_take && job_valid);
		end
	end

	always_ff @(posedge clk) begin
		if (enq) fifo_q[wr_ptr_q] <= nj;
	end
endmodule

// ===== rtl/core/rrm_back.sv =====
// Back part: address arithmetic and command emission.
module rrm_back import rrm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic job_valid,
	output logic job_take,
	input job_t job,
	input logic [BpdW-1:0] blocks_per_disk,
	output logic empty,
	input logic pop,
	output cmd_t cmd
);
	bk_state_t state_q, state_d;
	job_t job_q;
	logic [LbW-1:0] b_q;
	logic [3:0] d_q, p_q;
	logic [3:0] i_q;
	logic [MaxDisks-1:0] emitted_q;
	logic out_v_q;
	cmd_t out_q;
	logic div_start, div_done;
	logic [LbW-1:0] div_dd, quo;
	logic [3:0] div_dv, rem;
	logic out_free;
	logic div2_q;

	assign out_free = !out_v_q || pop;
	assign empty = !out_v_q;
	assign cmd = out_q;

	rrm_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dd),
		.divisor(div_dv), .done(div_done), .quotient(quo), .remainder(rem)
	);

	function automatic logic hok(input logic [MaxDisks-1:0] h, input logic [3:0] d);
		hok = (d < 4'(MaxDisks)) && h[DiskIdxW'(d)];
	endfunction

	logic in_rng;
	assign in_rng = (b_q < LbW'(blocks_per_disk)) && ((b_q >> BlockIndexBits) == '0);

	logic do_emit;
	cmd_t ec;
	logic e_last;
	logic [3:0] next_i;

	always_comb begin
		state_d = state_q;
		job_take = 1'b0;
		div_start = 1'b0;
		div_dd = job.lb;
		div_dv = job.n;
		do_emit = 1'b0;
		ec = '0;
		e_last = 1'b0;
		next_i = i_q;
		case (state_q)
			BK_IDLE: begin
				if (job_valid) begin
					job_take = 1'b1;
					if (job.err != ST_OK || job.level == LVL_RAID1) state_d = BK_CHECK;
					else begin
						div_start = 1'b1;
						if (job.level == LVL_RAID10) div_dv = {1'b0, job.n[3:1]};
						else if (job.level != LVL_RAID0) div_dv = job.n - 4'd1;
						state_d = BK_DIV1;
					end
				end
			end
			BK_DIV1: if (div_done)
				state_d = (job_q.level == LVL_RAID5 && !div2_q) ? BK_DIV2 : BK_CHECK;
			BK_DIV2: begin
				div_dd = quo;
				div_dv = job_q.n;
			end
			BK_CHECK: state_d = BK_EMIT;
			BK_EMIT: begin
				ec.status = ST_OK;
				ec.physical_block = b_q[BlockIndexBits-1:0];
				ec.disk_op = job_q.wr ? OP_WRITE : OP_READ;
				if (job_q.err != ST_OK) begin
					ec = '0;
					ec.disk_op = OP_NONE;
					ec.status = job_q.err;
					e_last = 1'b1;
				end else begin
					case (job_q.level)
						LVL_RAID0: begin
							ec.target_disk = d_q + 4'd1;
							ec.role = ROLE_DATA;
							e_last = 1'b1;
						end
						LVL_RAID1, LVL_RAID10: begin
							ec.target_disk = i_q + 4'd1;
							// The second disk of a striped pair is always the mirror copy.
							if (job_q.level == LVL_RAID10)
								ec.role = (i_q == p_q) ? ROLE_MIRROR : ROLE_DATA;
							else
								ec.role = (emitted_q == '0) ? ROLE_DATA : ROLE_MIRROR;
							e_last = 1'b1;
							next_i = i_q + 4'd1;
							for (int k = MaxDisks - 1; k >= 0; k--)
								if (4'(k) > i_q && 4'(k) <= p_q && job_q.wr &&
										hok(job_q.health, 4'(k))) begin
									e_last = 1'b0;
									next_i = 4'(k);
								end
						end
						default: begin
							if (job_q.wr) begin
								ec.disk_op = (i_q >= 4'd2) ? OP_WRITE : OP_READ;
								ec.role = (i_q == 4'd0 || i_q == 4'd3) ? ROLE_PARITY : ROLE_DATA;
								ec.target_disk = ((i_q == 4'd0 || i_q == 4'd3) ? p_q : d_q) + 4'd1;
								e_last = (i_q == 4'd3);
								next_i = i_q + 4'd1;
							end else if (hok(job_q.health, d_q)) begin
								ec.target_disk = d_q + 4'd1;
								ec.role = ROLE_DATA;
								e_last = 1'b1;
							end else begin
								ec.target_disk = i_q + 4'd1;
								ec.role = ROLE_RECON;
								e_last = 1'b1;
								next_i = i_q + 4'd1;
								for (int k = MaxDisks - 1; k >= 0; k--)
									if (4'(k) > i_q && 4'(k) < job_q.n && 4'(k) != d_q) begin
										e_last = 1'b0;
										next_i = 4'(k);
									end
							end
						end
					endcase
				end
				ec.last = e_last;
				if (out_free) begin
					do_emit = 1'b1;
					if (e_last) state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
		if (state_q == BK_DIV2) begin
			div_start = 1'b1;
			state_d = BK_DIV1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			out_v_q <= 1'b0;
			div2_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (do_emit) out_v_q <= 1'b1;
			else if (pop) out_v_q <= 1'b0;
			if (state_q == BK_DIV2) div2_q <= 1'b1;
			else if (state_q == BK_IDLE) div2_q <= 1'b0;
		end
	end

	// Datapath registers; the RAID5 second division finds the parity disk.
	always_ff @(posedge clk) begin
		if (do_emit) out_q <= ec;
		case (state_q)
			BK_IDLE: begin
				job_q <= job;
				b_q <= job.lb;
				i_q <= '0;
				emitted_q <= '0;
			end
			BK_DIV1: if (div_done) begin
				if (job_q.level == LVL_RAID5 && div2_q) begin
					p_q <= rem;
					if (d_q >= rem) d_q <= d_q + 4'd1;
				end else begin
					b_q <= quo;
					d_q <= rem;
					if (job_q.level == LVL_RAID4) p_q <= job_q.n - 4'd1;
				end
			end
			BK_CHECK: begin
				if (job_q.err == ST_OK) begin
					if (!in_rng) job_q.err <= ST_RANGE;
					else if (job_q.level == LVL_RAID1) begin
						p_q <= job_q.n - 4'd1;
						job_q.err <= ST_NO_COPY;
						for (int k = MaxDisks - 1; k >= 0; k--)
							if (4'(k) < job_q.n && hok(job_q.health, 4'(k))) begin
								i_q <= 4'(k);
								job_q.err <= ST_OK;
							end
					end else if (job_q.level == LVL_RAID10) begin
						p_q <= {d_q[2:0], 1'b0} + 4'd1;
						if (hok(job_q.health, {d_q[2:0], 1'b0})) i_q <= {d_q[2:0], 1'b0};
						else if (hok(job_q.health, {d_q[2:0], 1'b1}))
							i_q <= {d_q[2:0], 1'b1};
						else job_q.err <= ST_NO_COPY;
					end else if (job_q.level != LVL_RAID0 && !job_q.wr &&
							!hok(job_q.health, d_q)) begin
						for (int k = 0; k < MaxDisks; k++)
							if (4'(k) < job_q.n && 4'(k) != d_q && !job_q.health[k])
								job_q.err <= ST_NO_REBUILD;
						i_q <= (d_q == 4'd0) ? 4'd1 : 4'd0;
					end
				end
			end
			BK_EMIT: if (do_emit) begin
				i_q <= next_i;
				emitted_q <= emitted_q | 1'b1;
			end
			default: ;
		endcase
	end
endmodule

// ===== rtl/core/raid_request_mapper.sv =====
// Top level of the RAID request mapper: configuration, front and back parts.
//
//  Channel   Direction  Handshake            Payload
//  request   in         push / full         req_t (action, logical_block, disk_number)
//  command   out        empty / pop         cmd_t (disk_op ... last)
//  config    in         cfg_we              cfg_index, cfg_data
//
// Each division yields 27 quotient bits. A read or write transaction needs no division
// under mirroring, one division under striping, striped mirrors and dedicated parity,
// and two divisions under rotating parity; then one command leaves per cycle, up to
// eight, while pop keeps up. Fail and repair transactions only update the health bits
// and emit no command.
// Reset clears the health bits to all healthy and empties the job queue.
// The two-entry job queue lets requests be accepted while the back part is stalled
// on a command that has not been popped.
module raid_request_mapper import rrm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input req_t req,
	output logic empty,
	input logic pop,
	output cmd_t cmd,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [BpdW-1:0] cfg_data
);
	logic [2:0] raid_level_q;
	logic [3:0] disk_count_q;
	logic [BpdW-1:0] bpd_q;
	logic enabled_q;
	logic job_valid, job_take;
	job_t job;

	// Register file; every index of the two-bit port maps to a register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raid_level_q <= LVL_RAID0;
			disk_count_q <= 4'd8;
			bpd_q <= 25'd131071;
			enabled_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LEVEL: raid_level_q <= cfg_data[2:0];
				CFG_COUNT: disk_count_q <= cfg_data[3:0];
				CFG_BPD: bpd_q <= cfg_data;
				CFG_ENABLE: enabled_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	rrm_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .req(req),
		.raid_level(raid_level_q), .disk_count(disk_count_q),
		.array_enabled(enabled_q), .job_valid(job_valid), .job_take(job_take),
		.job(job)
	);

	rrm_back u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(job_valid), .job_take(job_take),
		.job(job), .blocks_per_disk(bpd_q), .empty(empty), .pop(pop), .cmd(cmd)
	);
endmodule
